FILE: hw/rtl/pol_pkg.sv
// ============================================================================
// pol_pkg: shared types and constants for the positional ordered list
// Command and status codes, storage geometry and field widths.
// ============================================================================
package pol_pkg;

    // Storage geometry
    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int LEN_W   = 7;
    localparam int VAL_W   = 32;
    localparam int CMD_W   = 4;
    localparam int POS_W   = 7;
    localparam int ST_W    = 2;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 4'd0,
        CMD_INS_END   = 4'd1,
        CMD_INS_POS   = 4'd2,
        CMD_RD_FIRST  = 4'd3,
        CMD_RD_LAST   = 4'd4,
        CMD_RD_POS    = 4'd5,
        CMD_RD_MID    = 4'd6,
        CMD_DEL_FIRST = 4'd7,
        CMD_DEL_LAST  = 4'd8,
        CMD_DEL_POS   = 4'd9,
        CMD_DEL_MID   = 4'd10
    } cmd_t;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // Operation class of an accepted request
    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_INS  = 2'd1,
        K_RD   = 2'd2,
        K_DEL  = 2'd3
    } kind_t;

endpackage

FILE: hw/rtl/positional_ordered_list_top.sv
// ============================================================================
// positional_ordered_list_top: ordered list engine with positional access
// Keeps up to DEPTH signed values in one entry RAM; inserts and deletes
// shift the stored entries one word per cycle through the RAM.
// ============================================================================
//
//  channel | direction | ports                                     | handshake
//  --------+-----------+-------------------------------------------+----------
//  request | in        | s_command, s_value, s_position            | s_valid/s_ready
//  result  | out       | m_result_value, m_status, m_list_length   | m_valid/m_ready
//
//  Rejected and unused commands go straight to the result step; reads fetch
//  and capture the entry; inserts shift the entries that move, then write
//  the new value; deletes fetch, capture, then shift the entries that move.
//  Shifts are paced by the entry RAM, which moves one word per cycle.
//  Reset clears the length and control state; entries are undefined until written, no sweep.
//  A stalled result holds in the output register; the next request is taken
//  meanwhile and waits in its final step until the result is taken.
// ============================================================================
module positional_ordered_list_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pol_pkg::CMD_W-1:0]         s_command,
    input  logic signed [pol_pkg::VAL_W-1:0]  s_value,
    input  logic [pol_pkg::POS_W-1:0]         s_position,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pol_pkg::VAL_W-1:0]  m_result_value,
    output logic [pol_pkg::ST_W-1:0]          m_status,
    output logic [pol_pkg::LEN_W-1:0]         m_list_length
);

    localparam int IDX_W = pol_pkg::IDX_W;
    localparam int LEN_W = pol_pkg::LEN_W;
    localparam int VAL_W = pol_pkg::VAL_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_CAPT  = 6'b000100,
        S_MOVE  = 6'b001000,
        S_PUT   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    // Control state
    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic                reading_reg, reading_next;
    logic                pend_reg, pend_next;
    logic                m_valid_reg, m_valid_next;

    // Request context and move pointers
    pol_pkg::kind_t      kind_reg, kind_next;
    pol_pkg::status_t    st_reg, st_next;
    logic [IDX_W-1:0]    tgt_reg, tgt_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [VAL_W-1:0]    res_reg, res_next;
    logic [IDX_W-1:0]    src_reg, src_next;
    logic [IDX_W-1:0]    end_reg, end_next;
    logic                up_reg, up_next;
    logic [IDX_W-1:0]    pend_addr_reg, pend_addr_next;

    // Output register
    logic [VAL_W-1:0]    m_result_value_reg, m_result_value_next;
    logic [pol_pkg::ST_W-1:0] m_status_reg, m_status_next;
    logic [LEN_W-1:0]    m_list_length_reg, m_list_length_next;

    // RAM port signals
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [VAL_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [VAL_W-1:0]    ram_rdata;

    // Decode of the incoming request
    pol_pkg::kind_t      dec_kind;
    pol_pkg::status_t    dec_st;
    logic [LEN_W-1:0]    dec_tgt;
    logic                dec_is_pos;
    logic [LEN_W-1:0]    cnt_m1;
    logic [LEN_W-1:0]    pos_m1;
    logic [LEN_W-1:0]    cnt_p1;
    logic                out_free;

    assign cnt_m1   = count_reg - LEN_W'(1);
    assign cnt_p1   = count_reg + LEN_W'(1);
    assign pos_m1   = LEN_W'(s_position) - LEN_W'(1);
    assign out_free = !m_valid_reg || m_ready;

    pol_ram #(
        .WIDTH (VAL_W),
        .DEPTH (pol_pkg::DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Classify the command, pick the target index and check bounds
    always_comb begin
        dec_tgt    = '0;
        dec_kind   = pol_pkg::K_NONE;
        dec_st     = pol_pkg::ST_OK;
        dec_is_pos = 1'b0;
        case (pol_pkg::cmd_t'(s_command))
            pol_pkg::CMD_INS_FRONT: dec_tgt = '0;
            pol_pkg::CMD_INS_END:   dec_tgt = count_reg;
            pol_pkg::CMD_INS_POS:   dec_tgt = pos_m1;
            pol_pkg::CMD_RD_FIRST:  dec_tgt = '0;
            pol_pkg::CMD_RD_LAST:   dec_tgt = cnt_m1;
            pol_pkg::CMD_RD_POS:    dec_tgt = pos_m1;
            pol_pkg::CMD_RD_MID:    dec_tgt = count_reg >> 1;
            pol_pkg::CMD_DEL_FIRST: dec_tgt = '0;
            pol_pkg::CMD_DEL_LAST:  dec_tgt = cnt_m1;
            pol_pkg::CMD_DEL_POS:   dec_tgt = pos_m1;
            pol_pkg::CMD_DEL_MID:   dec_tgt = count_reg >> 1;
            default:                dec_tgt = '0;
        endcase

        if (s_command inside {pol_pkg::CMD_INS_POS, pol_pkg::CMD_RD_POS,
                              pol_pkg::CMD_DEL_POS}) begin
            dec_is_pos = 1'b1;
        end

        if (s_command inside {[pol_pkg::CMD_INS_FRONT:pol_pkg::CMD_INS_POS]}) begin
            dec_kind = pol_pkg::K_INS;
        end else if (s_command inside {[pol_pkg::CMD_RD_FIRST:pol_pkg::CMD_RD_MID]}) begin
            dec_kind = pol_pkg::K_RD;
        end else if (s_command inside {[pol_pkg::CMD_DEL_FIRST:pol_pkg::CMD_DEL_MID]}) begin
            dec_kind = pol_pkg::K_DEL;
        end

        // Full and empty checks come before the position check
        if (dec_kind == pol_pkg::K_INS) begin
            if (count_reg == LEN_W'(pol_pkg::DEPTH)) begin
                dec_st = pol_pkg::ST_FULL;
            end else if (dec_is_pos && (s_position == '0 ||
                                        LEN_W'(s_position) > cnt_p1)) begin
                dec_st = pol_pkg::ST_BADPOS;
            end
        end else if (dec_kind != pol_pkg::K_NONE) begin
            if (count_reg == '0) begin
                dec_st = pol_pkg::ST_EMPTY;
            end else if (dec_is_pos && (s_position == '0 ||
                                        LEN_W'(s_position) > count_reg)) begin
                dec_st = pol_pkg::ST_BADPOS;
            end
        end
    end

    // Sequencer: fetch, shift and write back through the entry RAM
    always_comb begin
        state_next          = state_reg;
        count_next          = count_reg;
        reading_next        = reading_reg;
        pend_next           = pend_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        kind_next           = kind_reg;
        st_next             = st_reg;
        tgt_next            = tgt_reg;
        val_next            = val_reg;
        res_next            = res_reg;
        src_next            = src_reg;
        end_next            = end_reg;
        up_next             = up_reg;
        pend_addr_next      = pend_addr_reg;
        m_result_value_next = m_result_value_reg;
        m_status_next       = m_status_reg;
        m_list_length_next  = m_list_length_reg;
        ram_we              = 1'b0;
        ram_waddr           = pend_addr_reg;
        ram_wdata           = ram_rdata;
        ram_raddr           = src_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next = dec_kind;
                    st_next   = dec_st;
                    tgt_next  = dec_tgt[IDX_W-1:0];
                    val_next  = s_value;
                    res_next  = '0;
                    if (dec_st != pol_pkg::ST_OK || dec_kind == pol_pkg::K_NONE) begin
                        state_next = S_DONE;
                    end else if (dec_kind == pol_pkg::K_INS) begin
                        if (dec_tgt == count_reg) begin
                            state_next = S_PUT;
                        end else begin
                            state_next   = S_MOVE;
                            src_next     = cnt_m1[IDX_W-1:0];
                            end_next     = dec_tgt[IDX_W-1:0];
                            up_next      = 1'b1;
                            reading_next = 1'b1;
                            pend_next    = 1'b0;
                        end
                    end else begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                ram_raddr  = tgt_reg;
                state_next = S_CAPT;
            end
            S_CAPT: begin
                res_next = ram_rdata;
                if (kind_reg == pol_pkg::K_RD || tgt_reg == cnt_m1[IDX_W-1:0]) begin
                    state_next = S_DONE;
                end else begin
                    state_next   = S_MOVE;
                    src_next     = tgt_reg + IDX_W'(1);
                    end_next     = cnt_m1[IDX_W-1:0];
                    up_next      = 1'b0;
                    reading_next = 1'b1;
                    pend_next    = 1'b0;
                end
            end
            S_MOVE: begin
                // Write back the word read last cycle one slot over
                ram_raddr = src_reg;
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (reading_reg) begin
                    pend_next      = 1'b1;
                    pend_addr_next = up_reg ? src_reg + IDX_W'(1) : src_reg - IDX_W'(1);
                    if (src_reg == end_reg) begin
                        reading_next = 1'b0;
                    end else begin
                        src_next = up_reg ? src_reg - IDX_W'(1) : src_reg + IDX_W'(1);
                    end
                end else begin
                    pend_next  = 1'b0;
                    state_next = (kind_reg == pol_pkg::K_INS) ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = tgt_reg;
                ram_wdata  = val_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                // Hold until the output register is free
                if (out_free) begin
                    if (st_reg == pol_pkg::ST_OK && kind_reg == pol_pkg::K_INS) begin
                        count_next = cnt_p1;
                    end else if (st_reg == pol_pkg::ST_OK && kind_reg == pol_pkg::K_DEL) begin
                        count_next = cnt_m1;
                    end
                    m_valid_next        = 1'b1;
                    m_result_value_next = res_reg;
                    m_status_next       = st_reg;
                    m_list_length_next  = count_next;
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            reading_reg <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            reading_reg <= reading_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg           <= kind_next;
        st_reg             <= st_next;
        tgt_reg            <= tgt_next;
        val_reg            <= val_next;
        res_reg            <= res_next;
        src_reg            <= src_next;
        end_reg            <= end_next;
        up_reg             <= up_next;
        pend_addr_reg      <= pend_addr_next;
        m_result_value_reg <= m_result_value_next;
        m_status_reg       <= m_status_next;
        m_list_length_reg  <= m_list_length_next;
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_status       = m_status_reg;
    assign m_list_length  = m_list_length_reg;

`ifndef SYNTHESIS
    // Length never exceeds the storage depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LEN_W'(pol_pkg::DEPTH))
        else $error("list length exceeds depth");

    // A shift never writes the entry it reads in the same cycle
    a_move_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOVE && pend_reg && reading_reg) |-> (pend_addr_reg != src_reg))
        else $error("shift read and write collide");

    // A full report always comes with a full list
    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == pol_pkg::ST_FULL) |-> (m_list_length == LEN_W'(pol_pkg::DEPTH)))
        else $error("full status with short list");

    // Failed requests return a zero value
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != pol_pkg::ST_OK) |-> (m_result_value == '0))
        else $error("nonzero value on failed request");
`endif

endmodule

FILE: hw/rtl/pol_ram.sv
// ============================================================================
// pol_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module pol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: test/positional_ordered_list_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench: request/result check of positional_ordered_list_top
// Drives list commands through the valid/ready request port with random
// gaps and stalls, predicts every result from a queue-based list, and
// compares each returned result with the oldest prediction.
// ============================================================================
module testbench;

    localparam int DEPTH = pol_pkg::DEPTH;
    localparam int LEN_W = pol_pkg::LEN_W;
    localparam int VAL_W = pol_pkg::VAL_W;
    localparam int CMD_W = pol_pkg::CMD_W;
    localparam int POS_W = pol_pkg::POS_W;
    localparam int ST_W  = pol_pkg::ST_W;

    localparam int REQUEST_COUNT = 2000;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int QUEUE_AHEAD   = 4;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 150;
    localparam int MAX_REPORTS   = 10;

    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(int'(pol_pkg::CMD_DEL_MID) + 1);
    localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = '1;
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam int POS_TOP = (1 << POS_W) - 1;

    typedef struct {
        logic [CMD_W-1:0]        code;
        logic signed [VAL_W-1:0] val;
        logic [POS_W-1:0]        pos;
    } list_request_t;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        pol_pkg::status_t        status;
        logic [LEN_W-1:0]        length;
    } list_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_command = '0;
    logic signed [VAL_W-1:0]  s_value = '0;
    logic [POS_W-1:0]         s_position = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [VAL_W-1:0]  m_result_value;
    logic [ST_W-1:0]          m_status;
    logic [LEN_W-1:0]         m_list_length;

    // List contents as the block should hold them, front at index 0
    logic signed [VAL_W-1:0] list_model[$];
    list_request_t           pending_requests[$];
    list_result_t            expected_results[$];

    bit  req_accepted = 1'b0;
    bit  res_taken = 1'b0;
    bit  calm = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  send_gap = 0;
    int  rcv_gap = 0;
    int  n_queued = 0;
    int  n_accepted = 0;
    int  n_results = 0;
    int  n_errors = 0;
    int  n_full = 0;
    int  n_empty = 0;
    int  n_badpos = 0;
    int  cycle_count = 0;

    positional_ordered_list_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_value        (s_value),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_list_length  (m_list_length)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one command to the list copy and return the result it gives
    function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] code,
                                                        input logic signed [VAL_W-1:0] val,
                                                        input logic [POS_W-1:0] pos);
        list_result_t r;
        int           cnt;
        int           idx;
        bit           is_ins;
        bit           is_acc;
        bit           is_del;
        cnt = list_model.size();
        r.value = '0;
        r.status = pol_pkg::ST_OK;
        idx = 0;
        is_ins = 1'b0;
        is_acc = 1'b0;
        is_del = 1'b0;
        case (code)
            pol_pkg::CMD_INS_FRONT: begin is_ins = 1'b1; idx = 0; end
            pol_pkg::CMD_INS_END:   begin is_ins = 1'b1; idx = cnt; end
            pol_pkg::CMD_INS_POS:   begin is_ins = 1'b1; idx = int'(pos) - 1; end
            pol_pkg::CMD_RD_FIRST:  begin is_acc = 1'b1; idx = 0; end
            pol_pkg::CMD_RD_LAST:   begin is_acc = 1'b1; idx = cnt - 1; end
            pol_pkg::CMD_RD_POS:    begin is_acc = 1'b1; idx = int'(pos) - 1; end
            pol_pkg::CMD_RD_MID:    begin is_acc = 1'b1; idx = cnt / 2; end
            pol_pkg::CMD_DEL_FIRST: begin is_del = 1'b1; idx = 0; end
            pol_pkg::CMD_DEL_LAST:  begin is_del = 1'b1; idx = cnt - 1; end
            pol_pkg::CMD_DEL_POS:   begin is_del = 1'b1; idx = int'(pos) - 1; end
            pol_pkg::CMD_DEL_MID:   begin is_del = 1'b1; idx = cnt / 2; end
            default: ;
        endcase
        if (is_ins) begin
            // full takes priority over a bad position
            if (cnt >= DEPTH)
                r.status = pol_pkg::ST_FULL;
            else if (idx < 0 || idx > cnt)
                r.status = pol_pkg::ST_BADPOS;
            else
                list_model.insert(idx, val);
        end else if (is_acc || is_del) begin
            // empty takes priority over a bad position
            if (cnt == 0)
                r.status = pol_pkg::ST_EMPTY;
            else if (idx < 0 || idx >= cnt)
                r.status = pol_pkg::ST_BADPOS;
            else begin
                r.value = list_model[idx];
                if (is_del)
                    list_model.delete(idx);
            end
        end
        r.length = LEN_W'(list_model.size());
        return r;
    endfunction

    // Mostly short gaps, a few long ones, none in calm stretches
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Pick a position that is usually in 1..hi, sometimes anywhere
    function automatic int pick_position(input int hi);
        if (hi >= 1 && $urandom_range(0, 99) < 85)
            return int'($urandom_range(1, hi));
        return int'($urandom_range(0, POS_TOP));
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return VAL_MIN;
        if (r == 1)
            return VAL_MAX;
        return $urandom;
    endfunction

    // Queue a request, staying only a few requests ahead of the driver
    task automatic queue_request(input logic [CMD_W-1:0] code,
                                 input logic signed [VAL_W-1:0] val,
                                 input int pos);
        list_request_t req;
        while (pending_requests.size() >= QUEUE_AHEAD) begin
            @(posedge aclk);
            #1;
        end
        req.code = code;
        req.val = val;
        req.pos = POS_W'(pos);
        pending_requests.push_back(req);
        n_queued++;
    endtask

    // Drive requests at the falling edge; hold each until accepted
    always @(negedge aclk) begin
        list_request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_accepted) begin
            // hold the offered request
        end else if (send_gap > 0) begin
            send_gap--;
            s_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
            req = pending_requests.pop_front();
            s_command <= req.code;
            s_value <= req.val;
            s_position <= req.pos;
            s_valid <= 1'b1;
            send_gap = pick_gap();
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Drive result ready with random stalls and the one long hold-off
    always @(negedge aclk) begin
        if (rcv_gap > 0) begin
            rcv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (hold_left == 0);
            if (res_taken || $urandom_range(0, 15) == 0)
                rcv_gap = pick_gap();
        end
    end

    // Count down the long receiver hold-off once enough results have come
    always @(posedge aclk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && n_results >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Predict on each accepted request, check each accepted result
    always @(posedge aclk) begin
        list_result_t exp_res;
        if (!aresetn) begin
            req_accepted = 1'b0;
            res_taken = 1'b0;
        end else begin
            req_accepted = s_valid && s_ready;
            res_taken = m_valid && m_ready;
            if (req_accepted) begin
                exp_res = apply_list_command(s_command, s_value, s_position);
                expected_results.push_back(exp_res);
                n_accepted++;
                case (exp_res.status)
                    pol_pkg::ST_FULL:   n_full++;
                    pol_pkg::ST_EMPTY:  n_empty++;
                    pol_pkg::ST_BADPOS: n_badpos++;
                    default: ;
                endcase
            end
            if (res_taken) begin
                n_results <= n_results + 1;
                if (expected_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("[%0t] result with nothing expected: value %0d status %0d",
                                 $realtime, m_result_value, m_status);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_result_value !== exp_res.value || m_status !== exp_res.status ||
                        m_list_length !== exp_res.length) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS) begin
                            $display("[%0t] result mismatch: value exp %0d got %0d",
                                     $realtime, exp_res.value, m_result_value);
                            $display("    status exp %0d got %0d, length exp %0d got %0d",
                                     exp_res.status, m_status, exp_res.length,
                                     m_list_length);
                        end
                    end
                end
            end
        end
    end

    // End the run at the cycle limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("positional_ordered_list_top: mismatch");
            $finish;
        end
    end

    // Reset, then directed requests, random phases, drain and verdict
    initial begin
        int phase;
        int span;
        int est;
        int r;
        logic [CMD_W-1:0] code;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty list: empty status comes before any position check
        queue_request(pol_pkg::CMD_RD_FIRST, '0, 0);
        queue_request(pol_pkg::CMD_DEL_MID, '0, 0);
        queue_request(pol_pkg::CMD_DEL_POS, VAL_MAX, 0);
        queue_request(pol_pkg::CMD_RD_LAST, '0, 1);
        // bad insert positions, then insert into the empty list
        queue_request(pol_pkg::CMD_INS_POS, VAL_MAX, 0);
        queue_request(pol_pkg::CMD_INS_POS, VAL_MAX, 2);
        queue_request(pol_pkg::CMD_INS_POS, VAL_MIN, 1);
        // one-entry list: delete last and delete middle
        queue_request(pol_pkg::CMD_DEL_LAST, '0, POS_TOP);
        queue_request(pol_pkg::CMD_INS_END, VAL_MAX, 0);
        queue_request(pol_pkg::CMD_DEL_MID, '0, 0);
        // build a three-entry list, read every way, then delete it
        queue_request(pol_pkg::CMD_INS_FRONT, -1, 0);
        queue_request(pol_pkg::CMD_INS_END, '0, 0);
        queue_request(pol_pkg::CMD_INS_POS, VAL_MAX, POS_TOP);
        queue_request(pol_pkg::CMD_INS_POS, 32'sh5555_5555, 3);
        queue_request(pol_pkg::CMD_RD_FIRST, '0, 0);
        queue_request(pol_pkg::CMD_RD_LAST, '0, 0);
        queue_request(pol_pkg::CMD_RD_MID, '0, 0);
        queue_request(pol_pkg::CMD_RD_POS, '0, 2);
        queue_request(pol_pkg::CMD_RD_POS, '0, 0);
        queue_request(pol_pkg::CMD_RD_POS, '0, 4);
        queue_request(pol_pkg::CMD_DEL_POS, '0, 2);
        queue_request(pol_pkg::CMD_DEL_FIRST, '0, 0);
        queue_request(pol_pkg::CMD_DEL_LAST, '0, 0);
        // unused command codes leave the list alone
        queue_request(CMD_FIRST_UNUSED, VAL_MIN, POS_TOP);
        queue_request(CMD_LAST_UNUSED, VAL_MAX, 0);

        // random phases: fill to full, drain to empty, or mix
        while (n_queued < REQUEST_COUNT) begin
            calm = ($urandom_range(0, 3) == 0);
            phase = $urandom_range(0, 2);
            span = (phase == 2) ? $urandom_range(40, 120) : DEPTH + 6;
            repeat (span) begin
                est = list_model.size();
                r = $urandom_range(0, 99);
                if (phase == 0 && r < 90)
                    code = CMD_W'(int'(pol_pkg::CMD_INS_FRONT) + int'($urandom_range(0, 2)));
                else if (phase == 1 && r < 90)
                    code = CMD_W'(int'(pol_pkg::CMD_DEL_FIRST) + int'($urandom_range(0, 3)));
                else if (r < 97)
                    code = CMD_W'($urandom_range(int'(pol_pkg::CMD_INS_FRONT),
                                                 int'(pol_pkg::CMD_DEL_MID)));
                else
                    code = CMD_W'($urandom_range(int'(CMD_FIRST_UNUSED),
                                                 int'(CMD_LAST_UNUSED)));
                queue_request(code, pick_value(),
                              pick_position((code == pol_pkg::CMD_INS_POS) ? est + 1 : est));
            end
        end
        calm = 1'b0;

        // drain: wait for every request and result, then settle
        while (pending_requests.size() > 0 || s_valid || expected_results.size() > 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        #1;

        $display("%0d requests accepted, %0d results checked in %0d cycles",
                 n_accepted, n_results, cycle_count);
        $display("rejections seen: %0d list full, %0d list empty, %0d bad position",
                 n_full, n_empty, n_badpos);
        if (n_errors == 0) begin
            $display("positional_ordered_list_top: match");
        end else begin
            $display("%0d failing results", n_errors);
            $display("positional_ordered_list_top: mismatch");
        end
        $finish;
    end

endmodule
